// ----- hw/rtl/ssfs_pkg.sv -----
// ----------------------------------------------------------------------------
// ssfs_pkg
// Shared types and codes of the sparse-set field store: transaction payloads,
// operation codes and status codes.
// ----------------------------------------------------------------------------
package ssfs_pkg;

    // Payload field widths.
    localparam int OP_W     = 3;
    localparam int ENTITY_W = 12;
    localparam int SEL_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int OCC_W    = 7;

    // Largest number of results that one iterate command produces.
    localparam int MAX_RUN = 64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd2;
    localparam logic [OP_W-1:0] OP_SET     = 3'd3;
    localparam logic [OP_W-1:0] OP_ITERATE = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd5;

    // Command transaction.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ENTITY_W-1:0] entity;
        logic [SEL_W-1:0]    field_select;
        logic [VALUE_W-1:0]  value_a;
        logic [VALUE_W-1:0]  value_b;
        logic [VALUE_W-1:0]  value_c;
        logic [VALUE_W-1:0]  value_d;
    } cmd_item_t;

    // Response transaction.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTITY_W-1:0] entity_out;
        logic [SLOT_W-1:0]   slot;
        logic [VALUE_W-1:0]  field_a;
        logic [VALUE_W-1:0]  field_b;
        logic [VALUE_W-1:0]  field_c;
        logic [VALUE_W-1:0]  field_d;
        logic [OCC_W-1:0]    occupancy;
        logic                last;
    } rsp_item_t;

endpackage

// ----- hw/rtl/ssfs_cmd_if.sv -----
// ----------------------------------------------------------------------------
// ssfs_cmd_if
// Valid/ready channel that carries command transactions into the store.
// ----------------------------------------------------------------------------
interface ssfs_cmd_if;
    import ssfs_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ----- hw/rtl/ssfs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ssfs_rsp_if
// Valid/ready channel that carries response transactions out of the store.
// ----------------------------------------------------------------------------
interface ssfs_rsp_if;
    import ssfs_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ----- hw/rtl/sparse_set_field_store_unit.sv -----
// ----------------------------------------------------------------------------
// sparse_set_field_store_unit
// Keyed record store organized as a sparse set with swap-and-pop removal.
// A sparse map RAM takes an entity id to a dense slot; a dense RAM holds the
// entity id of each slot and one RAM per field runs parallel to it.
// ----------------------------------------------------------------------------
// Sequence: insert, lookup, set and a remove of the last slot read the sparse
// map, then the dense and field RAMs, and load the registered response once
// the output register is free. A remove that moves the last record then runs
// the move through the one read port of the dense and field RAMs after the
// result is issued. Iterate issues each result by a read, then a load of the
// output register; clear and rejected commands go straight to the response.
// Reset: all MAP_DEPTH sparse entries (at most 4096) are set to all ones, one
// entry a cycle, with cmd.ready low; record count resets to zero.
module sparse_set_field_store_unit #(
    parameter int ENTITY_SPACE = 4096,
    parameter int CAPACITY     = 64,
    parameter int FIELD_WIDTH  = 32,
    parameter int FIELD_COUNT  = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    ssfs_cmd_if.sink   cmd,
    ssfs_rsp_if.source rsp
);
    import ssfs_pkg::*;

    // Derived sizes. Ids above the id port range can never be addressed.
    localparam int ID_LIMIT  = 2 ** ENTITY_W;
    localparam int MAP_DEPTH = (ENTITY_SPACE < ID_LIMIT) ? ENTITY_SPACE : ID_LIMIT;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int SW        = $clog2(CAPACITY);
    localparam int CW        = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_DIRECT,
        S_ITER_RD,
        S_ITER_OUT,
        S_MOVE_RD,
        S_MOVE_WR
    } state_t;

    // Registers.
    state_t              state_reg, state_next;
    cmd_item_t           item_reg, item_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]       s_reg, s_next;
    logic                s_ok_reg, s_ok_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SW-1:0]       idx_reg, idx_next;
    logic [MAP_AW-1:0]   init_reg, init_next;
    logic                rsp_valid_reg;
    rsp_item_t           rsp_data_reg, rsp_next;

    // RAM ports.
    logic                   sp_we, sp_re;
    logic [MAP_AW-1:0]      sp_waddr, sp_raddr;
    logic [CW-1:0]          sp_wdata, sparse_rdata;
    logic                   dn_we;
    logic [SW-1:0]          dn_waddr;
    logic [ENTITY_W-1:0]    dn_wdata, dense_rdata;
    logic [FIELD_COUNT-1:0] fl_we;
    logic [SW-1:0]          fl_waddr;
    logic [FIELD_WIDTH-1:0] fl_wdata  [FIELD_COUNT];
    logic [FIELD_WIDTH-1:0] fld_rdata [FIELD_COUNT];
    logic                   rd_re;
    logic [SW-1:0]          rd_addr;

    // Datapath helpers.
    logic                   cmd_fire, out_free, rsp_load, in_range;
    logic                   found, full, iter_last;
    logic                   with_fields, use_ins, use_set;
    logic [SW-1:0]          slot_idx, cnt_idx;
    logic [STATUS_W-1:0]    rsp_status;
    logic [ENTITY_W-1:0]    rsp_entity;
    logic                   rsp_last;
    logic [31:0]            rsp_slot_w, rsp_occ_w;
    logic [VALUE_W-1:0]     in_vals  [4];
    logic [VALUE_W-1:0]     out_vals [4];
    logic [FIELD_WIDTH-1:0] ins_val  [FIELD_COUNT];
    logic [FIELD_WIDTH-1:0] fld_src  [FIELD_COUNT];
    logic [FIELD_WIDTH-1:0] set_val;

    // Memories.
    ssfs_ram #(.WIDTH(CW), .DEPTH(MAP_DEPTH)) u_sparse (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .re    (sp_re),
        .raddr (sp_raddr),
        .rdata (sparse_rdata)
    );

    ssfs_ram #(.WIDTH(ENTITY_W), .DEPTH(CAPACITY)) u_dense (
        .clk   (clk),
        .we    (dn_we),
        .waddr (dn_waddr),
        .wdata (dn_wdata),
        .re    (rd_re),
        .raddr (rd_addr),
        .rdata (dense_rdata)
    );

    for (genvar g = 0; g < FIELD_COUNT; g++)
    begin : g_field
        ssfs_ram #(.WIDTH(FIELD_WIDTH), .DEPTH(CAPACITY)) u_field (
            .clk   (clk),
            .we    (fl_we[g]),
            .waddr (fl_waddr),
            .wdata (fl_wdata[g]),
            .re    (rd_re),
            .raddr (rd_addr),
            .rdata (fld_rdata[g])
        );
    end

    // Handshake and status terms.
    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign in_range   = (32'(cmd.data.entity) < ENTITY_SPACE);
    assign slot_idx   = s_reg[SW-1:0];
    assign cnt_idx    = count_reg[SW-1:0];
    assign found      = s_ok_reg && (dense_rdata == item_reg.entity);
    assign full       = (count_reg >= CW'(CAPACITY));
    assign iter_last  = ((32'(idx_reg) + 32'd1) == 32'(count_reg))
                     || ((32'(idx_reg) + 32'd1) == MAX_RUN);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.data   = rsp_data_reg;

    // Field values of the held command, fitted to the field width.
    always_comb
    begin
        logic [63:0] wide;
        in_vals[0] = item_reg.value_a;
        in_vals[1] = item_reg.value_b;
        in_vals[2] = item_reg.value_c;
        in_vals[3] = item_reg.value_d;
        for (int j = 0; j < FIELD_COUNT; j++)
        begin
            wide = 64'(in_vals[j & 3]);
            ins_val[j] = (j < 4) ? wide[FIELD_WIDTH-1:0] : '0;
        end
        wide = 64'(item_reg.value_a);
        set_val = wide[FIELD_WIDTH-1:0];
    end

    // Sequencer: next state, RAM accesses and the response.
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        status_next = status_reg;
        s_next      = s_reg;
        s_ok_next   = s_ok_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        init_next   = init_reg;

        rsp_load    = 1'b0;
        rsp_status  = ST_OK;
        rsp_entity  = item_reg.entity;
        rsp_slot_w  = 32'd0;
        rsp_last    = 1'b1;
        with_fields = 1'b0;
        use_ins     = 1'b0;
        use_set     = 1'b0;

        sp_we    = 1'b0;
        sp_waddr = item_reg.entity[MAP_AW-1:0];
        sp_wdata = count_reg;
        sp_re    = 1'b0;
        sp_raddr = cmd.data.entity[MAP_AW-1:0];
        dn_we    = 1'b0;
        dn_waddr = slot_idx;
        dn_wdata = dense_rdata;
        fl_we    = '0;
        fl_waddr = slot_idx;
        for (int j = 0; j < FIELD_COUNT; j++)
        begin
            fl_wdata[j] = fld_rdata[j];
        end
        rd_re   = 1'b0;
        rd_addr = idx_reg;

        case (state_reg)
            S_INIT:
            begin
                // Sweep the sparse map to the invalid mark.
                sp_we    = 1'b1;
                sp_waddr = init_reg;
                sp_wdata = '1;
                if (init_reg == MAP_AW'(MAP_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_next = init_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    item_next = cmd.data;
                    case (cmd.data.op)
                        OP_ITERATE:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DIRECT;
                            end
                            else
                            begin
                                state_next = S_ITER_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            status_next = ST_OK;
                            state_next  = S_DIRECT;
                        end
                        OP_INSERT, OP_REMOVE, OP_LOOKUP, OP_SET:
                        begin
                            if (in_range)
                            begin
                                sp_re      = 1'b1;
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_DIRECT;
                            end
                        end
                        default:
                        begin
                            // Unknown codes produce no response.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                // Sparse entry is back; fetch the dense slot it names.
                rd_re      = 1'b1;
                rd_addr    = sparse_rdata[SW-1:0];
                s_next     = sparse_rdata;
                s_ok_next  = (sparse_rdata < count_reg);
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (out_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                    case (item_reg.op)
                        OP_INSERT:
                        begin
                            if (found)
                            begin
                                rsp_status  = ST_PRESENT;
                                rsp_slot_w  = 32'(s_reg);
                                with_fields = 1'b1;
                            end
                            else if (full)
                            begin
                                rsp_status = ST_FULL;
                            end
                            else
                            begin
                                // Append at the end of the dense list.
                                dn_we       = 1'b1;
                                dn_waddr    = cnt_idx;
                                dn_wdata    = item_reg.entity;
                                fl_we       = '1;
                                fl_waddr    = cnt_idx;
                                for (int j = 0; j < FIELD_COUNT; j++)
                                begin
                                    fl_wdata[j] = ins_val[j];
                                end
                                sp_we       = 1'b1;
                                count_next  = count_reg + 1'b1;
                                rsp_slot_w  = 32'(count_reg);
                                with_fields = 1'b1;
                                use_ins     = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (found)
                            begin
                                // Report the removed record, then fill the hole.
                                rsp_slot_w  = 32'(s_reg);
                                with_fields = 1'b1;
                                count_next  = count_reg - 1'b1;
                                if (s_reg != CW'(count_reg - 1'b1))
                                begin
                                    state_next = S_MOVE_RD;
                                end
                            end
                            else
                            begin
                                rsp_status = ST_NOT_PRESENT;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (found)
                            begin
                                rsp_slot_w  = 32'(s_reg);
                                with_fields = 1'b1;
                            end
                            else
                            begin
                                rsp_status = ST_NOT_PRESENT;
                            end
                        end
                        OP_SET:
                        begin
                            if (found)
                            begin
                                for (int j = 0; j < FIELD_COUNT; j++)
                                begin
                                    fl_we[j]    = (32'(item_reg.field_select) == j);
                                    fl_wdata[j] = set_val;
                                end
                                rsp_slot_w  = 32'(s_reg);
                                with_fields = 1'b1;
                                use_set     = 1'b1;
                            end
                            else
                            begin
                                rsp_status = ST_NOT_PRESENT;
                            end
                        end
                        default:
                        begin
                            rsp_load = 1'b0;
                        end
                    endcase
                end
            end

            S_DIRECT:
            begin
                // Responses that carry no record: errors, empty, clear.
                if (out_free)
                begin
                    rsp_load   = 1'b1;
                    rsp_status = status_reg;
                    state_next = S_IDLE;
                    if (item_reg.op == OP_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end

            S_ITER_RD:
            begin
                rd_re      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_ITER_OUT;
            end

            S_ITER_OUT:
            begin
                if (out_free)
                begin
                    rsp_load    = 1'b1;
                    rsp_entity  = dense_rdata;
                    rsp_slot_w  = 32'(idx_reg);
                    rsp_last    = iter_last;
                    with_fields = 1'b1;
                    if (iter_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_ITER_RD;
                    end
                end
            end

            S_MOVE_RD:
            begin
                // The count already points at the old last slot.
                rd_re      = 1'b1;
                rd_addr    = cnt_idx;
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                // Last record into the freed slot; repoint its sparse entry.
                dn_we      = 1'b1;
                fl_we      = '1;
                sp_we      = 1'b1;
                sp_waddr   = dense_rdata[MAP_AW-1:0];
                sp_wdata   = s_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Response fields.
        for (int j = 0; j < FIELD_COUNT; j++)
        begin
            if (use_ins)
            begin
                fld_src[j] = ins_val[j];
            end
            else if (use_set && (32'(item_reg.field_select) == j))
            begin
                fld_src[j] = set_val;
            end
            else
            begin
                fld_src[j] = fld_rdata[j];
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            logic [63:0] wide_out;
            wide_out = '0;
            if (with_fields && (k < FIELD_COUNT))
            begin
                wide_out = 64'(fld_src[k]);
            end
            out_vals[k] = wide_out[VALUE_W-1:0];
        end
        rsp_occ_w = 32'(count_next);

        rsp_next.status     = rsp_status;
        rsp_next.entity_out = rsp_entity;
        rsp_next.slot       = rsp_slot_w[SLOT_W-1:0];
        rsp_next.field_a    = out_vals[0];
        rsp_next.field_b    = out_vals[1];
        rsp_next.field_c    = out_vals[2];
        rsp_next.field_d    = out_vals[3];
        rsp_next.occupancy  = rsp_occ_w[OCC_W-1:0];
        rsp_next.last       = rsp_last;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            item_reg      <= '0;
            status_reg    <= ST_OK;
            s_reg         <= '0;
            s_ok_reg      <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            init_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            item_reg   <= item_next;
            status_reg <= status_next;
            s_reg      <= s_next;
            s_ok_reg   <= s_ok_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            init_reg   <= init_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_data_reg  <= rsp_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // The record count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("record count above capacity");

    // A successful insert grows the store by exactly one record.
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && (state_reg == S_CHECK) && (item_reg.op == OP_INSERT)
            && (rsp_next.status == ST_OK))
        |=> (32'(count_reg) == 32'($past(count_reg)) + 32'd1))
        else $error("insert did not grow the record count");

    // A successful remove shrinks the store by exactly one record.
    a_remove_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && (state_reg == S_CHECK) && (item_reg.op == OP_REMOVE)
            && (rsp_next.status == ST_OK))
        |=> (32'(count_reg) + 32'd1 == 32'($past(count_reg))))
        else $error("remove did not shrink the record count");

    // Iteration only reads live slots.
    a_iter_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER_RD) |-> (CW'(idx_reg) < count_reg))
        else $error("iteration read past the record count");

    // A command is never taken in the cycle a response is loaded.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |-> !rsp_load)
        else $error("command accepted while a response was loading");

endmodule

// ----- hw/rtl/ssfs_ram.sv -----
// ----------------------------------------------------------------------------
// ssfs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module ssfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
